// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers for the RTL; aef_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define AEF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define AEF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AEF_ASSERT(lbl, clk, rst_n, prop)
`define AEF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/aef_pkg.sv -----
`default_nettype none
package aef_pkg;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int MAX_HEIGHT    = 4096;
    localparam int COL_BITS      = 12;
    localparam int ROW_BITS      = 13;
    localparam int CENTRE_WEIGHT = 12;
    localparam int GAIN_DIVISOR  = 12240;
    localparam int RECIP_SHIFT   = 34;
    localparam logic [20:0] RECIP = 21'((64'd1 << RECIP_SHIFT) / 64'd12240);
    localparam int SAT_LIMIT     = 256 * GAIN_DIVISOR;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH_GAIN   = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [1:0]          slot_c;
        logic [1:0]          slot_p;
        logic [1:0]          slot_q;
        logic [31:0]         px;
        logic                do_blur;
        logic                do_out;
        logic                up3;
        logic                left_ok;
        logic                right_ok;
        logic                down_ok;
        logic                fend;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_WRITE,
        BK_LEFT,
        BK_RIGHT,
        BK_UPPER,
        BK_BLUR,
        BK_MUL,
        BK_RECIP,
        BK_QUOT,
        BK_EMIT
    } back_state_t;

    function automatic logic [1:0] slot_prev(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : 2'(s - 2'd1);
    endfunction

    function automatic logic [7:0] blend8(input logic [7:0] c, input logic pos,
                                          input logic [8:0] v8);
        logic [16:0] acc;
        acc = (pos ? 17'(17'd255 * 17'(v8)) : 17'd0)
            + 17'(17'(c) * (17'd256 - 17'(v8)));
        return acc[15:8];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/alpha_emboss_filter_unit.sv -----
`default_nettype none
// Alpha emboss filter: RGBA pixels in raster order on the input channel
// (in_valid/in_ready), embossed pixels on the output channel
// (out_valid/out_ready). Each frame is followed by two rows of drain
// requests (opcode 1); drain requests inside the frame are dropped.
// Results lag the input by two rows; frame_end marks the last pixel.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// a write to the width, height or gain register restarts the frame position.
// The back-end sequencer handles one request at a time: it reads the
// neighbouring pixels and blur values one at a time from the line memories
// and, when the request yields a result, runs multiply, reciprocal and blend
// steps before it takes the next request from the queue.
// A two-entry request queue sits between the front and back end; the
// result waits in an output register. When the receiver stalls the back end
// holds at its final step, the queue fills and in_ready drops.
// Reset clears position, queue and output valid and restores the register
// defaults; line memory contents are not cleared.
module alpha_emboss_filter_unit #(
    parameter int MAX_WIDTH = aef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic [7:0]  alpha_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic [7:0]       alpha_out,
    output logic             frame_end
);
    import aef_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [8:0]         width_reg;
    logic [12:0]        height_reg;
    logic [11:0]        gain_reg;
    logic               restart;
    logic [CW-1:0]      wm1;
    logic [11:0]        hm1;
    logic signed [11:0] gain;

    logic q_full, q_push, q_valid, q_pop;
    cmd_t push_cmd, pop_cmd;

    assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                                cfg_index == REG_IMAGE_HEIGHT ||
                                cfg_index == REG_DEPTH_GAIN);
    assign gain    = $signed(gain_reg);

    always_comb
    begin
        if (width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(width_reg - 9'd1);
        end
        if (height_reg == '0)
        begin
            hm1 = '0;
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            hm1 = 12'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = 12'(height_reg - 13'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 13'd1;
            gain_reg   <= 12'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[8:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_DEPTH_GAIN:   gain_reg   <= cfg_data[11:0];
                default:          gain_reg   <= gain_reg;
            endcase
        end
    end

    aef_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .wm1      (wm1),
        .hm1      (hm1),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .alpha_in (alpha_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    aef_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    aef_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .depth_gain (gain),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .frame_end  (frame_end)
    );
endmodule
`default_nettype wire

// ----- rtl/aef_ram.sv -----
`default_nettype none
module aef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/aef_front.sv -----
`default_nettype none
module aef_front #(
    parameter int MAX_WIDTH = aef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         restart,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wm1,
    input  wire logic [11:0]                  hm1,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         opcode,
    input  wire logic [7:0]                   red_in,
    input  wire logic [7:0]                   green_in,
    input  wire logic [7:0]                   blue_in,
    input  wire logic [7:0]                   alpha_in,
    input  wire logic                         q_full,
    output logic                              q_push,
    output aef_pkg::cmd_t                     q_cmd
);
    import aef_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [1:0]          slot_reg, slot_next;
    logic                drain_pos;
    logic                row_end;
    logic [ROW_BITS-1:0] h_ext;

    assign h_ext     = ROW_BITS'(hm1);
    assign drain_pos = row_reg > h_ext;
    assign in_ready  = !q_full;
    assign q_push    = in_valid && !q_full && !(opcode == OP_DRAIN && !drain_pos);
    assign row_end   = col_reg == wm1;

    always_comb
    begin
        q_cmd.col      = COL_BITS'(col_reg);
        q_cmd.slot_c   = slot_reg;
        q_cmd.slot_p   = slot_prev(slot_reg);
        q_cmd.slot_q   = slot_prev(slot_prev(slot_reg));
        q_cmd.px       = drain_pos ? 32'd0 : {alpha_in, blue_in, green_in, red_in};
        q_cmd.do_blur  = row_reg != '0;
        q_cmd.do_out   = row_reg >= ROW_BITS'(2);
        q_cmd.up3      = row_reg >= ROW_BITS'(3);
        q_cmd.left_ok  = col_reg != '0;
        q_cmd.right_ok = !row_end;
        q_cmd.down_ok  = row_reg <= h_ext + ROW_BITS'(1);
        q_cmd.fend     = (row_reg == h_ext + ROW_BITS'(2)) && row_end;
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = 2'd0;
        end
        else if (q_push)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (row_reg == h_ext + ROW_BITS'(2))
                begin
                    row_next  = '0;
                    slot_next = 2'd0;
                end
                else
                begin
                    row_next  = row_reg + ROW_BITS'(1);
                    slot_next = (slot_reg == 2'd2) ? 2'd0 : 2'(slot_reg + 2'd1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= 2'd0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/aef_queue.sv -----
`default_nettype none
module aef_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  aef_pkg::cmd_t      push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output aef_pkg::cmd_t      pop_cmd
);
    import aef_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          entry [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = count_reg == (PW+1)'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign pop_cmd = entry[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + PW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/aef_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module aef_back #(
    parameter int MAX_WIDTH = aef_pkg::MAX_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [11:0] depth_gain,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  aef_pkg::cmd_t           q_cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              red_out,
    output logic [7:0]              green_out,
    output logic [7:0]              blue_out,
    output logic [7:0]              alpha_out,
    output logic                    frame_end
);
    import aef_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] addr_of(input logic [1:0] s, input logic [CW-1:0] c);
        return AW'(32'(s) * MAX_WIDTH + 32'(c));
    endfunction

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;

    logic [CW-1:0] col, col_l, col_r;

    logic          pix_we, blur_we;
    logic [AW-1:0] pix_waddr, pix_raddr, blur_waddr, blur_raddr;
    logic [31:0]   pix_rd;
    logic [11:0]   blur_rd;
    logic [11:0]   blur_sum;
    logic signed [13:0] diff_calc;
    logic          out_load;

    logic [7:0]         a_c_reg, a_l_reg, a_r_reg;
    logic [11:0]        b_up_reg, b_l_reg, b_r_reg;
    logic [31:0]        px_reg;
    logic signed [13:0] diff_reg;
    logic signed [25:0] prod_reg;
    logic [21:0]        mag_reg;
    logic [42:0]        t_reg;
    logic               sat_reg, pos_reg;
    logic [8:0]         v8_reg;

    logic               out_valid_reg;
    logic [7:0]         red_out_reg, green_out_reg, blue_out_reg, alpha_out_reg;
    logic               frame_end_reg;

    logic [25:0] mag_full;
    logic [8:0]  q0;
    logic [21:0] rem;
    logic [8:0]  quot;

    assign col   = cmd_reg.col[CW-1:0];
    assign col_l = cmd_reg.left_ok ? CW'(col - CW'(1)) : col;
    assign col_r = cmd_reg.right_ok ? CW'(col + CW'(1)) : col;

    assign pix_waddr  = addr_of(cmd_reg.slot_c, col);
    assign blur_waddr = addr_of(cmd_reg.slot_p, col);

    aef_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (cmd_reg.px),
        .raddr (pix_raddr),
        .rdata (pix_rd)
    );

    aef_ram #(.WIDTH(12), .DEPTH(DEPTH)) u_blur_ram (
        .clk   (clk),
        .we    (blur_we),
        .waddr (blur_waddr),
        .wdata (blur_sum),
        .raddr (blur_raddr),
        .rdata (blur_rd)
    );

    always_comb
    begin
        blur_sum = 12'(CENTRE_WEIGHT * 32'(a_c_reg)) + 12'(cmd_reg.px[31:24]);
        if (cmd_reg.do_out)
        begin
            blur_sum = blur_sum + 12'(pix_rd[31:24]);
        end
        if (cmd_reg.left_ok)
        begin
            blur_sum = blur_sum + 12'(a_l_reg);
        end
        if (cmd_reg.right_ok)
        begin
            blur_sum = blur_sum + 12'(a_r_reg);
        end
    end

    always_comb
    begin
        diff_calc = '0;
        if (cmd_reg.down_ok)
        begin
            diff_calc = diff_calc + $signed({2'b00, blur_sum});
        end
        if (cmd_reg.right_ok)
        begin
            diff_calc = diff_calc + $signed({2'b00, b_r_reg});
        end
        if (cmd_reg.up3)
        begin
            diff_calc = diff_calc - $signed({2'b00, b_up_reg});
        end
        if (cmd_reg.left_ok)
        begin
            diff_calc = diff_calc - $signed({2'b00, b_l_reg});
        end
    end

    always_comb
    begin
        mag_full = prod_reg[25] ? 26'(-prod_reg) : 26'(prod_reg);
        q0       = t_reg[42:34];
        rem      = mag_reg - 22'(23'(q0) * 23'(GAIN_DIVISOR));
        quot     = (rem >= 22'(GAIN_DIVISOR)) ? 9'(q0 + 9'd1) : q0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  state_next = q_valid ? BK_WRITE : BK_IDLE;
            BK_WRITE: state_next = BK_LEFT;
            BK_LEFT:  state_next = BK_RIGHT;
            BK_RIGHT: state_next = BK_UPPER;
            BK_UPPER: state_next = BK_BLUR;
            BK_BLUR:  state_next = cmd_reg.do_out ? BK_MUL : BK_IDLE;
            BK_MUL:   state_next = BK_RECIP;
            BK_RECIP: state_next = BK_QUOT;
            BK_QUOT:  state_next = BK_EMIT;
            BK_EMIT:  state_next = (!out_valid_reg || out_ready) ? BK_IDLE : BK_EMIT;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        pix_we     = 1'b0;
        blur_we    = 1'b0;
        out_load   = 1'b0;
        pix_raddr  = addr_of(cmd_reg.slot_p, col);
        blur_raddr = addr_of(cmd_reg.slot_c, col);
        case (state_reg)
            BK_IDLE:  q_pop = q_valid;
            BK_WRITE: pix_we = 1'b1;
            BK_LEFT:
            begin
                pix_raddr  = addr_of(cmd_reg.slot_p, col_l);
                blur_raddr = addr_of(cmd_reg.slot_q, col_l);
            end
            BK_RIGHT:
            begin
                pix_raddr  = addr_of(cmd_reg.slot_p, col_r);
                blur_raddr = addr_of(cmd_reg.slot_q, col_r);
            end
            BK_UPPER: pix_raddr = addr_of(cmd_reg.slot_q, col);
            BK_BLUR:  blur_we = cmd_reg.do_blur;
            BK_EMIT:  out_load = !out_valid_reg || out_ready;
            default:  q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        case (state_reg)
            BK_LEFT:
            begin
                a_c_reg  <= pix_rd[31:24];
                b_up_reg <= blur_rd;
            end
            BK_RIGHT:
            begin
                a_l_reg <= pix_rd[31:24];
                b_l_reg <= blur_rd;
            end
            BK_UPPER:
            begin
                a_r_reg <= pix_rd[31:24];
                b_r_reg <= blur_rd;
            end
            BK_BLUR:
            begin
                px_reg   <= pix_rd;
                diff_reg <= diff_calc;
            end
            BK_MUL:   prod_reg <= diff_reg * depth_gain;
            BK_RECIP:
            begin
                mag_reg <= mag_full[21:0];
                sat_reg <= mag_full >= 26'(SAT_LIMIT);
                pos_reg <= !prod_reg[25] && (prod_reg != '0);
                t_reg   <= 43'(mag_full[21:0]) * 43'(RECIP);
            end
            BK_QUOT:  v8_reg <= sat_reg ? 9'd256 : quot;
            default:  v8_reg <= v8_reg;
        endcase
        if (out_load)
        begin
            red_out_reg   <= blend8(px_reg[7:0], pos_reg, v8_reg);
            green_out_reg <= blend8(px_reg[15:8], pos_reg, v8_reg);
            blue_out_reg  <= blend8(px_reg[23:16], pos_reg, v8_reg);
            alpha_out_reg <= px_reg[31:24];
            frame_end_reg <= cmd_reg.fend;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;
    assign alpha_out = alpha_out_reg;
    assign frame_end = frame_end_reg;

    `AEF_ASSERT(a_out_hold, clk, rst_n, (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(red_out_reg) && $stable(frame_end_reg)))
    `AEF_ASSERT(a_mul_has_result, clk, rst_n, (state_reg == BK_MUL) |-> cmd_reg.do_out)
    `AEF_ASSERT(a_weight_range, clk, rst_n, (state_reg == BK_EMIT) |-> (v8_reg <= 9'd256))
    `AEF_ASSERT_NEVER(a_pop_busy, clk, rst_n, q_pop && (state_reg != BK_IDLE))
endmodule
`default_nettype wire

// ----- dv/alpha_emboss_filter_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module alpha_emboss_filter_unit_tb;
    import aef_pkg::*;

    typedef struct {
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] alpha;
        bit       fend;
    } emboss_pixel_t;

    class emboss_scoreboard;
        bit [31:0]     pix_line[3][256];
        int            blur_line[3][256];
        int            col;
        int            row;
        bit [8:0]      width_reg;
        bit [12:0]     height_reg;
        bit [11:0]     gain_reg;
        emboss_pixel_t awaited[$];
        int            errors;

        function void clear();
            foreach (pix_line[i, j]) begin
                pix_line[i][j] = 0;
                blur_line[i][j] = 0;
            end
            col = 0;
            row = 0;
            width_reg = 256;
            height_reg = 1;
            gain_reg = 256;
            errors = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > 256) return 256;
            return width_reg;
        endfunction

        function int eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > 4096) return 4096;
            return height_reg;
        endfunction

        function void write_reg(bit [1:0] idx, bit [12:0] data);
            if (idx == REG_IMAGE_WIDTH) width_reg = data[8:0];
            else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
            else if (idx == REG_DEPTH_GAIN) gain_reg = data[11:0];
            else return;
            col = 0;
            row = 0;
        endfunction

        function int alpha_of(int s, int x);
            return pix_line[s][x][31:24];
        endfunction

        function bit [7:0] mix(bit [7:0] c, int tgt, int v8);
            return 8'((tgt * v8 + int'(c) * (256 - v8)) >>> 8);
        endfunction

        function void note_request(bit op, bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                   bit [7:0] a);
            int w, h, x, y, s, sum, diff, gain, prod, mag, v8, tgt;
            bit drain_pos;
            bit [31:0] px;
            emboss_pixel_t res;
            w = eff_width();
            h = eff_height();
            x = (col >= w) ? w - 1 : col;
            drain_pos = row >= h;
            if (op == OP_DRAIN && !drain_pos) return;
            pix_line[row % 3][x] = drain_pos ? 32'd0 : {a, b, g, r};
            if (row >= 1) begin
                y = row - 1;
                s = y % 3;
                sum = CENTRE_WEIGHT * alpha_of(s, x) + alpha_of(row % 3, x);
                if (y >= 1) sum += alpha_of((y - 1) % 3, x);
                if (x >= 1) sum += alpha_of(s, x - 1);
                if (x + 1 < w) sum += alpha_of(s, x + 1);
                blur_line[s][x] = sum;
            end
            if (row >= 2) begin
                y = row - 2;
                s = y % 3;
                diff = 0;
                if (y >= 1) diff -= blur_line[(y - 1) % 3][x];
                if (y + 1 < h) diff += blur_line[(y + 1) % 3][x];
                if (x >= 1) diff -= blur_line[s][x - 1];
                if (x + 1 < w) diff += blur_line[s][x + 1];
                gain = int'($signed(gain_reg));
                prod = diff * gain;
                mag = prod < 0 ? -prod : prod;
                v8 = mag / GAIN_DIVISOR;
                if (v8 > 256) v8 = 256;
                tgt = prod > 0 ? 255 : 0;
                px = pix_line[s][x];
                res.red = mix(px[7:0], tgt, v8);
                res.green = mix(px[15:8], tgt, v8);
                res.blue = mix(px[23:16], tgt, v8);
                res.alpha = px[31:24];
                res.fend = (y == h - 1 && x == w - 1);
                awaited.push_back(res);
            end
            x++;
            if (x >= w) begin
                x = 0;
                row++;
                if (row >= h + 2) row = 0;
            end
            col = x;
        endfunction

        function void check_pixel(emboss_pixel_t got);
            emboss_pixel_t exp_px;
            if (awaited.size() == 0) begin
                $error("unexpected result red=%0d alpha=%0d", got.red, got.alpha);
                errors++;
                return;
            end
            exp_px = awaited.pop_front();
            if (got.red !== exp_px.red) begin
                $error("red_out expected %0d actual %0d", exp_px.red, got.red);
                errors++;
            end
            if (got.green !== exp_px.green) begin
                $error("green_out expected %0d actual %0d", exp_px.green, got.green);
                errors++;
            end
            if (got.blue !== exp_px.blue) begin
                $error("blue_out expected %0d actual %0d", exp_px.blue, got.blue);
                errors++;
            end
            if (got.alpha !== exp_px.alpha) begin
                $error("alpha_out expected %0d actual %0d", exp_px.alpha, got.alpha);
                errors++;
            end
            if (got.fend !== exp_px.fend) begin
                $error("frame_end expected %0d actual %0d", exp_px.fend, got.fend);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        frame_end;

    emboss_scoreboard sb;
    bit               calm_in;
    bit               calm_out;
    int               sent;
    longint           cycles;

    alpha_emboss_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(bit op, bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] a);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        alpha_in <= a;
        do @(posedge clk); while (!in_ready);
        sb.note_request(op, r, g, b, a);
        sent++;
    endtask

    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [12:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic configure(bit [12:0] w, bit [12:0] h, bit [12:0] g);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_DEPTH_GAIN, g);
        if ($urandom_range(0, 3) == 0) write_reg(2'd3, 13'($urandom));
    endtask

    // one frame plus its two drain rows; noise adds stray drains and late pixels
    task automatic run_frame(bit noise);
        int n_pix, n_drain;
        n_pix = sb.eff_width() * sb.eff_height();
        n_drain = 2 * sb.eff_width();
        for (int i = 0; i < n_pix; i++) begin
            if (noise && $urandom_range(0, 9) == 0)
                send_request(OP_DRAIN, pick_byte(), pick_byte(), pick_byte(), pick_byte());
            send_request(OP_PIXEL, pick_byte(), pick_byte(), pick_byte(), pick_byte());
        end
        for (int i = 0; i < n_drain; i++) begin
            if (noise && $urandom_range(0, 3) == 0)
                send_request(OP_PIXEL, pick_byte(), pick_byte(), pick_byte(), pick_byte());
            else
                send_request(OP_DRAIN, 8'd0, 8'd0, 8'd0, 8'd0);
        end
    endtask

    initial
    begin
        emboss_pixel_t got;
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm_out ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.red = red_out;
            got.green = green_out;
            got.blue = blue_out;
            got.alpha = alpha_out;
            got.fend = frame_end;
            sb.check_pixel(got);
        end
    end

    initial
    begin
        int w, h;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_PIXEL;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        alpha_in = '0;
        calm_in = 1'b0;
        calm_out = 1'b0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(13'd3, 13'd2, 13'd1024);
        send_request(OP_PIXEL, 8'd0, 8'd255, 8'd0, 8'd255);
        send_request(OP_DRAIN, 8'd1, 8'd2, 8'd3, 8'd4);
        send_request(OP_PIXEL, 8'd255, 8'd0, 8'd255, 8'd0);
        send_request(OP_PIXEL, 8'd128, 8'd127, 8'd1, 8'd255);
        send_request(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
        send_request(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255);
        send_request(OP_PIXEL, 8'd7, 8'd200, 8'd90, 8'd0);
        send_request(OP_PIXEL, 8'd9, 8'd9, 8'd9, 8'd9);
        for (int i = 0; i < 5; i++) send_request(OP_DRAIN, 8'd0, 8'd0, 8'd0, 8'd0);
        configure(13'd3, 13'd1, 13'h1C00);
        run_frame(1'b1);
        configure(13'd0, 13'd0, 13'h0800);
        run_frame(1'b1);

        // tall frame cut short; the next write restarts the position
        configure(13'd1, 13'd4500, 13'd777);
        for (int i = 0; i < 150; i++)
            send_request(OP_PIXEL, pick_byte(), pick_byte(), pick_byte(), pick_byte());
        configure(13'd511, 13'd1, 13'h07FF);
        run_frame(1'b0);
        configure(13'd40, 13'd2, -13'sd1024);
        run_frame(1'b1);

        while (sent < 1900)
        begin
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = $urandom_range(257, 511);
                default: w = $urandom_range(1, 12);
            endcase
            h = (w == 0 || w > 12) ? $urandom_range(0, 1) : $urandom_range(0, 8);
            calm_in = $urandom_range(0, 4) == 0;
            calm_out = $urandom_range(0, 4) == 0;
            configure(13'(w), 13'(h),
                      $urandom_range(0, 4) == 0 ? 13'($urandom)
                                                : 13'($urandom_range(0, 2048) - 1024));
            run_frame($urandom_range(0, 4) == 0);
        end

        calm_in = 1'b0;
        calm_out = 1'b0;
        settle();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
